@@ rtl/scre_pkg.sv @@
// Shared types and constants for the signed-count run-length encoder.
// Used by scre_lit_mem, scre_ctrl, the top level and the port checker.
// No dependencies.
`timescale 1ns / 1ps

package scre_pkg;

    localparam int BYTE_W       = 8;
    localparam int HDR_W        = 16;
    localparam int RUN_W        = 7;
    localparam int MAX_RUN_DEF  = 127;
    localparam int MAX_LIT_DEF  = 127;

    typedef enum logic {
        OP_DATA = 1'b0,
        OP_EOS  = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [BYTE_W-1:0]   data_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]   first_byte;
        logic [BYTE_W-1:0]   second_byte;
        logic                second_valid;
        logic                last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_PREP,
        ST_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_SINGLE,
        JOB_PAIR,
        JOB_FLUSH
    } t_job;

endpackage

@@ rtl/scre_lit_mem.sv @@
// Literal byte store: one write port, two registered read ports.
// Depends on scre_pkg for the byte width.
`timescale 1ns / 1ps

module scre_lit_mem #(
    parameter int  DEPTH = scre_pkg::MAX_LIT_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [scre_pkg::BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr_a,
    input  logic [AW-1:0]               i_raddr_b,
    output logic [scre_pkg::BYTE_W-1:0] o_rdata_a,
    output logic [scre_pkg::BYTE_W-1:0] o_rdata_b
);

    logic [scre_pkg::BYTE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ rtl/scre_ctrl.sv @@
// Encoder control: stream state, packet decisions, literal flush sequencer
// and the output register. Depends on scre_pkg; drives scre_lit_mem.
`timescale 1ns / 1ps

module scre_ctrl #(
    parameter int  MAX_RUN     = scre_pkg::MAX_RUN_DEF,
    parameter int  MAX_LITERAL = scre_pkg::MAX_LIT_DEF,
    localparam int AW          = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  scre_pkg::t_in_item          i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output scre_pkg::t_out_item         o_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [scre_pkg::HDR_W-1:0]  i_cfg_data,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [scre_pkg::BYTE_W-1:0] o_mem_wdata,
    output logic [AW-1:0]               o_mem_raddr_a,
    output logic [AW-1:0]               o_mem_raddr_b,
    input  logic [scre_pkg::BYTE_W-1:0] i_mem_rdata_a,
    input  logic [scre_pkg::BYTE_W-1:0] i_mem_rdata_b
);

    localparam int CW = $clog2(MAX_LITERAL + 1);
    localparam int PW = CW + 1;
    localparam int BW = scre_pkg::BYTE_W;
    localparam int RW = scre_pkg::RUN_W;

    scre_pkg::t_state            r_state, n_state;
    logic [scre_pkg::HDR_W-1:0]  r_hdr_bytes;
    logic [scre_pkg::HDR_W-1:0]  r_seen, n_seen;
    logic                        r_pend, n_pend;
    logic                        r_in_run, n_in_run;
    logic [BW-1:0]               r_prev, n_prev;
    logic [RW-1:0]               r_run_len, n_run_len;
    logic [CW-1:0]               r_lit_cnt, n_lit_cnt;
    logic [BW-1:0]               r_e0, r_e1;
    logic                        r_e1_vld;
    logic [CW-1:0]               r_n;
    logic [PW-1:0]               r_pos, n_pos;
    logic                        r_out_vld;
    scre_pkg::t_out_item         r_out;

    scre_pkg::t_job              w_job;
    logic                        w_acc;
    logic [BW-1:0]               w_e0;
    logic                        w_e1_vld;
    logic                        w_we;
    logic [CW-1:0]               w_flush_n;
    logic                        w_slot_free;
    logic                        w_load;
    scre_pkg::t_out_item         w_out;
    logic                        w_fl_last;
    logic                        w_fl_sv;
    logic [BW-1:0]               w_hdr;
    logic [PW-1:0]               w_pos_m1;

    assign w_acc       = i_valid && o_ready;
    assign w_slot_free = !r_out_vld || i_ready;
    assign w_fl_last   = (r_pos + PW'(1)) >= PW'(r_n);
    assign w_fl_sv     = r_pos < PW'(r_n);
    assign w_hdr       = ~BW'(r_n) + BW'(1);
    assign w_pos_m1    = n_pos - PW'(1);

    // packet decision for the item on the input channel
    always_comb begin
        n_seen    = r_seen;
        n_pend    = r_pend;
        n_in_run  = r_in_run;
        n_prev    = r_prev;
        n_run_len = r_run_len;
        n_lit_cnt = r_lit_cnt;
        w_job     = scre_pkg::JOB_NONE;
        w_e0      = i_data.data_byte;
        w_e1_vld  = 1'b1;
        w_we      = 1'b0;
        w_flush_n = r_lit_cnt;
        priority if (i_data.opcode == scre_pkg::OP_EOS) begin
            if (r_pend) begin
                if (r_in_run) begin
                    w_job = scre_pkg::JOB_PAIR;
                    w_e0  = BW'(r_run_len);
                end else begin
                    // pending byte joins the literals, then flush all
                    w_we      = 1'b1;
                    w_job     = scre_pkg::JOB_FLUSH;
                    w_flush_n = r_lit_cnt + CW'(1);
                end
            end
            n_seen    = '0;
            n_pend    = 1'b0;
            n_in_run  = 1'b0;
            n_prev    = '0;
            n_run_len = '0;
            n_lit_cnt = '0;
        end else if (r_seen < r_hdr_bytes) begin
            n_seen   = r_seen + scre_pkg::HDR_W'(1);
            w_job    = scre_pkg::JOB_SINGLE;
            w_e1_vld = 1'b0;
        end else if (!r_pend) begin
            n_prev   = i_data.data_byte;
            n_pend   = 1'b1;
            n_in_run = 1'b0;
        end else if (r_in_run) begin
            if (r_run_len >= RW'(MAX_RUN) || i_data.data_byte != r_prev) begin
                w_job     = scre_pkg::JOB_PAIR;
                w_e0      = BW'(r_run_len);
                n_in_run  = 1'b0;
                n_run_len = '0;
                n_prev    = i_data.data_byte;
            end else begin
                n_run_len = r_run_len + RW'(1);
            end
        end else begin
            if (i_data.data_byte == r_prev) begin
                if (r_lit_cnt != '0) begin
                    w_job = scre_pkg::JOB_FLUSH;
                end
                n_lit_cnt = '0;
                n_in_run  = 1'b1;
                n_run_len = RW'(2);
            end else begin
                w_we = 1'b1;
                if (r_lit_cnt == CW'(MAX_LITERAL - 1)) begin
                    w_job     = scre_pkg::JOB_FLUSH;
                    w_flush_n = r_lit_cnt + CW'(1);
                    n_lit_cnt = '0;
                end else begin
                    n_lit_cnt = r_lit_cnt + CW'(1);
                end
                n_prev = i_data.data_byte;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scre_pkg::ST_IDLE: begin
                if (w_acc) begin
                    unique case (w_job)
                        scre_pkg::JOB_SINGLE,
                        scre_pkg::JOB_PAIR:   n_state = scre_pkg::ST_EMIT;
                        scre_pkg::JOB_FLUSH:  n_state = scre_pkg::ST_PREP;
                        default:              n_state = scre_pkg::ST_IDLE;
                    endcase
                end
            end
            scre_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = scre_pkg::ST_IDLE;
                end
            end
            scre_pkg::ST_PREP: n_state = scre_pkg::ST_FLUSH;
            scre_pkg::ST_FLUSH: begin
                if (w_slot_free && w_fl_last) begin
                    n_state = scre_pkg::ST_IDLE;
                end
            end
            default: n_state = scre_pkg::ST_IDLE;
        endcase
    end

    // state outputs: handshake, output load, flush read position
    always_comb begin
        o_ready = 1'b0;
        w_load  = 1'b0;
        n_pos   = r_pos;
        w_out   = '0;
        unique case (r_state)
            scre_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                n_pos   = '0;
            end
            scre_pkg::ST_EMIT: begin
                w_load             = w_slot_free;
                w_out.first_byte   = r_e0;
                w_out.second_byte  = r_e1_vld ? r_e1 : '0;
                w_out.second_valid = r_e1_vld;
                w_out.last         = 1'b1;
            end
            scre_pkg::ST_PREP: begin
                n_pos = r_pos;
            end
            scre_pkg::ST_FLUSH: begin
                w_load             = w_slot_free;
                w_out.first_byte   = (r_pos == '0) ? w_hdr : i_mem_rdata_a;
                w_out.second_byte  = w_fl_sv ? i_mem_rdata_b : '0;
                w_out.second_valid = w_fl_sv;
                w_out.last         = w_fl_last;
                if (w_slot_free) begin
                    n_pos = r_pos + PW'(2);
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // read data always matches r_pos: addresses follow its next value
    assign o_mem_raddr_a = w_pos_m1[AW-1:0];
    assign o_mem_raddr_b = n_pos[AW-1:0];
    assign o_mem_we      = w_acc && w_we;
    assign o_mem_waddr   = r_lit_cnt[AW-1:0];
    assign o_mem_wdata   = r_prev;

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_vld;
    assign o_data        = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scre_pkg::ST_IDLE;
            r_hdr_bytes <= '0;
            r_seen      <= '0;
            r_pend      <= 1'b0;
            r_in_run    <= 1'b0;
            r_prev      <= '0;
            r_run_len   <= '0;
            r_lit_cnt   <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_hdr_bytes <= i_cfg_data;
            end
            if (w_acc) begin
                r_seen    <= n_seen;
                r_pend    <= n_pend;
                r_in_run  <= n_in_run;
                r_prev    <= n_prev;
                r_run_len <= n_run_len;
                r_lit_cnt <= n_lit_cnt;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (w_acc) begin
            r_e0     <= w_e0;
            r_e1     <= r_prev;
            r_e1_vld <= w_e1_vld;
            r_n      <= w_flush_n;
        end
        if (w_load) begin
            r_out <= w_out;
        end
    end

endmodule

@@ rtl/signed_count_rle_encoder.sv @@
// Top level of the signed-count run-length encoder.
// Depends on scre_pkg, scre_lit_mem and scre_ctrl.
//
// Usage: bytes enter on the i_valid/o_ready channel as t_in_item, opcode
// data or end of stream. Encoded bytes leave on the o_valid/i_ready channel
// as t_out_item, up to two bytes per transfer, last set on the final transfer
// caused by one input item. The user must write the header_bytes register
// through the i_cfg_valid/o_cfg_ready channel (always ready) only while
// the block idles; the block itself does not enforce this. An item that
// produces nothing leaves the input ready for the next item. A pass-through
// byte or a run packet passes through the emit state and holds the input
// until its transfer is loaded. A literal flush of N bytes primes the store
// read in the prep state, then moves one transfer per cycle from the two
// read ports while the slot is free: ceil((N+1)/2) transfers, at most 64.
// When the receiver stalls, the output register holds its transfer; the
// block may take the next input meanwhile and waits for the slot to clear.
// Reset (synchronous, active low) clears the stream state, the register and
// the output valid. The literal store needs no clearing pass.
`timescale 1ns / 1ps

module signed_count_rle_encoder #(
    parameter int MAX_RUN     = scre_pkg::MAX_RUN_DEF,
    parameter int MAX_LITERAL = scre_pkg::MAX_LIT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  scre_pkg::t_in_item          i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output scre_pkg::t_out_item         o_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [scre_pkg::HDR_W-1:0]  i_cfg_data
);

    localparam int AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

    logic                        w_mem_we;
    logic [AW-1:0]               w_mem_waddr;
    logic [scre_pkg::BYTE_W-1:0] w_mem_wdata;
    logic [AW-1:0]               w_mem_raddr_a;
    logic [AW-1:0]               w_mem_raddr_b;
    logic [scre_pkg::BYTE_W-1:0] w_mem_rdata_a;
    logic [scre_pkg::BYTE_W-1:0] w_mem_rdata_b;

    scre_ctrl #(
        .MAX_RUN     (MAX_RUN),
        .MAX_LITERAL (MAX_LITERAL)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data        (i_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data        (o_data),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mem_we      (w_mem_we),
        .o_mem_waddr   (w_mem_waddr),
        .o_mem_wdata   (w_mem_wdata),
        .o_mem_raddr_a (w_mem_raddr_a),
        .o_mem_raddr_b (w_mem_raddr_b),
        .i_mem_rdata_a (w_mem_rdata_a),
        .i_mem_rdata_b (w_mem_rdata_b)
    );

    scre_lit_mem #(
        .DEPTH (MAX_LITERAL)
    ) u_lit_mem (
        .i_clk     (i_clk),
        .i_we      (w_mem_we),
        .i_waddr   (w_mem_waddr),
        .i_wdata   (w_mem_wdata),
        .i_raddr_a (w_mem_raddr_a),
        .i_raddr_b (w_mem_raddr_b),
        .o_rdata_a (w_mem_rdata_a),
        .o_rdata_b (w_mem_rdata_b)
    );

endmodule

@@ rtl/scre_checker.sv @@
// Port-level checks for signed_count_rle_encoder, attached by bind.
// Depends on scre_pkg for the payload types.
`timescale 1ns / 1ps

module scre_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                o_ready,
    input  logic                o_valid,
    input  logic                i_ready,
    input  scre_pkg::t_out_item o_data
);

    // a stalled transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_sec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.second_valid |-> o_data.second_byte == 8'd0)
        else $error("unused second byte not zero");

    // a lone byte can only close an item's output
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.second_valid |-> o_data.last)
        else $error("single-byte transfer not marked last");

    // input ready drops only after a transfer on the input channel
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(o_ready) |-> $past(i_valid))
        else $error("input ready dropped without a transfer");

endmodule

bind signed_count_rle_encoder scre_checker u_scre_checker (.*);

@@ tb/scre_stream_checker.sv @@
`timescale 1ns / 1ps
// Stream checker for signed_count_rle_encoder: encodes every accepted input
// byte on its own and compares the output transfers in order.
// Depends on scre_pkg.

module scre_stream_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  scre_pkg::t_in_item           i_in_item,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  scre_pkg::t_out_item          i_out_item,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [scre_pkg::HDR_W-1:0]   i_cfg_data,
    output int                           o_mismatches,
    output int                           o_outstanding
);

    logic [scre_pkg::HDR_W-1:0]   copy_limit;
    logic [scre_pkg::HDR_W-1:0]   copied;
    logic                         held_valid;
    logic                         in_run;
    logic [scre_pkg::BYTE_W-1:0]  held_byte;
    logic [scre_pkg::RUN_W-1:0]   run_len;
    logic [7:0]                   lit_cnt;
    logic [scre_pkg::BYTE_W-1:0]  lit_store [0:127];
    logic [scre_pkg::BYTE_W-1:0]  packet_bytes [$];
    scre_pkg::t_out_item          expected_pairs [$];
    int                           mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void restart_stream();
        copied     = '0;
        held_valid = 1'b0;
        in_run     = 1'b0;
        held_byte  = '0;
        run_len    = '0;
        lit_cnt    = '0;
    endfunction

    function automatic void flush_literals();
        if (lit_cnt == 0)
            return;
        // literal header is -N as a two's complement byte
        packet_bytes.push_back(8'h00 - lit_cnt);
        for (int i = 0; i < lit_cnt; i++)
            packet_bytes.push_back(lit_store[i]);
        lit_cnt = '0;
    endfunction

    function automatic void hold_literal();
        lit_store[lit_cnt[6:0]] = held_byte;
        lit_cnt = lit_cnt + 8'd1;
    endfunction

    function automatic void emit_run();
        packet_bytes.push_back({1'b0, run_len});
        packet_bytes.push_back(held_byte);
        in_run  = 1'b0;
        run_len = '0;
    endfunction

    task automatic encode_item(input scre_pkg::t_in_item it);
        int                  nres;
        scre_pkg::t_out_item r;
        packet_bytes.delete();
        if (it.opcode == scre_pkg::OP_EOS) begin
            if (held_valid) begin
                if (in_run) begin
                    emit_run();
                end else begin
                    hold_literal();
                    flush_literals();
                end
            end
            restart_stream();
        end else if (copied < copy_limit) begin
            copied = copied + 1'b1;
            packet_bytes.push_back(it.data_byte);
        end else if (!held_valid) begin
            held_byte  = it.data_byte;
            held_valid = 1'b1;
            in_run     = 1'b0;
        end else if (in_run) begin
            // a capped run leaves and the new byte starts afresh
            if (run_len >= scre_pkg::MAX_RUN_DEF || it.data_byte != held_byte) begin
                emit_run();
                held_byte = it.data_byte;
            end else begin
                run_len = run_len + 1'b1;
            end
        end else if (it.data_byte == held_byte) begin
            flush_literals();
            in_run  = 1'b1;
            run_len = 7'd2;
        end else begin
            hold_literal();
            if (lit_cnt >= scre_pkg::MAX_LIT_DEF)
                flush_literals();
            held_byte = it.data_byte;
        end

        nres = (packet_bytes.size() + 1) / 2;
        for (int k = 0; k < nres; k++) begin
            r.first_byte   = packet_bytes[2*k];
            r.second_valid = (2*k + 1 < packet_bytes.size());
            r.second_byte  = r.second_valid ? packet_bytes[2*k + 1] : 8'h00;
            r.last         = (k == nres - 1);
            expected_pairs.push_back(r);
        end
    endtask

    task automatic compare_transfer(input scre_pkg::t_out_item got);
        scre_pkg::t_out_item exp;
        if (expected_pairs.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer %h", got));
            return;
        end
        exp = expected_pairs.pop_front();
        if (got.first_byte !== exp.first_byte)
            report_mismatch($sformatf("first_byte %h, expected %h",
                                      got.first_byte, exp.first_byte));
        if (got.second_byte !== exp.second_byte)
            report_mismatch($sformatf("second_byte %h, expected %h",
                                      got.second_byte, exp.second_byte));
        if (got.second_valid !== exp.second_valid)
            report_mismatch($sformatf("second_valid %b, expected %b",
                                      got.second_valid, exp.second_valid));
        if (got.last !== exp.last)
            report_mismatch($sformatf("last %b, expected %b", got.last, exp.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            copy_limit = '0;
            restart_stream();
            expected_pairs.delete();
        end else begin
            // drain before predicting: a new item cannot yield a transfer this cycle
            if (i_out_valid && i_out_ready)
                compare_transfer(i_out_item);
            if (i_cfg_valid && i_cfg_ready)
                copy_limit = i_cfg_data;
            if (i_in_valid && i_in_ready)
                encode_item(i_in_item);
        end
        o_outstanding = expected_pairs.size();
        o_mismatches  = mismatches;
    end

endmodule

@@ tb/signed_count_rle_encoder_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for signed_count_rle_encoder: drives byte streams and
// header_bytes writes with random gaps and stalls, and gives the verdict.
// Depends on scre_pkg, the encoder RTL and scre_stream_checker.

module signed_count_rle_encoder_tb;

    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ITEMS  = 40;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic                         o_ready;
    scre_pkg::t_in_item           i_data      = '0;
    logic                         o_valid;
    logic                         i_ready     = 1'b0;
    scre_pkg::t_out_item          o_data;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [scre_pkg::HDR_W-1:0]   i_cfg_data  = '0;

    int                           mismatches;
    int                           outstanding;
    int                           quiet       = 0;
    int                           stall_left  = 0;
    int                           random_sent = 0;
    bit                           steady      = 1'b0;
    logic [scre_pkg::BYTE_W-1:0]  last_byte   = '0;

    signed_count_rle_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    scre_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_item     (i_data),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_item    (o_data),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones, none while steady
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [scre_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return last_byte;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [scre_pkg::HDR_W-1:0] pick_copy_count();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // end the run after too many cycles without a transfer on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_item(input scre_pkg::t_opcode op,
                             input logic [scre_pkg::BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_data  <= '{opcode: op, data_byte: b};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (op == scre_pkg::OP_DATA)
            last_byte = b;
    endtask

    // hold the sender until every expected transfer is back, then let it settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_copy_count(input logic [scre_pkg::HDR_W-1:0] v);
        wait_idle();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_literals(input int len);
        logic [scre_pkg::BYTE_W-1:0] v;
        v = last_byte;
        repeat (len) begin
            v = v ^ 8'($urandom_range(1, 255));
            send_item(scre_pkg::OP_DATA, v);
        end
    endtask

    task automatic send_random_stream();
        int                          target;
        int                          n;
        int                          len;
        int                          kind;
        logic [scre_pkg::BYTE_W-1:0] v;
        target = $urandom_range(6, 30);
        n = 0;
        while (n < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 6);
                v = pick_byte();
                repeat (len) send_item(scre_pkg::OP_DATA, v);
            end else if (kind < 8) begin
                len = $urandom_range(1, 8);
                send_literals(len);
            end else begin
                len = $urandom_range(1, 4);
                repeat (len) send_item(scre_pkg::OP_DATA, pick_byte());
            end
            n += len;
        end
        random_sent += n;
        // now and then leave the stream open into the next one
        if ($urandom_range(0, 9) != 0) begin
            send_item(scre_pkg::OP_EOS, 8'($urandom));
            random_sent++;
        end
    endtask

    initial begin
        int                          stream_no;
        logic [scre_pkg::BYTE_W-1:0] v;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two copied bytes, a run, literals ending in a run, flushes
        write_copy_count(16'd2);
        send_item(scre_pkg::OP_DATA, 8'h00);
        send_item(scre_pkg::OP_DATA, 8'hFF);
        repeat (3) send_item(scre_pkg::OP_DATA, 8'hAA);
        send_item(scre_pkg::OP_DATA, 8'h01);
        send_item(scre_pkg::OP_DATA, 8'h80);
        send_item(scre_pkg::OP_DATA, 8'h7F);
        send_item(scre_pkg::OP_DATA, 8'h7F);
        send_item(scre_pkg::OP_EOS, 8'h00);
        send_item(scre_pkg::OP_EOS, 8'hFF);
        send_item(scre_pkg::OP_DATA, 8'h55);
        send_item(scre_pkg::OP_DATA, 8'h01);
        send_item(scre_pkg::OP_DATA, 8'h10);
        send_item(scre_pkg::OP_EOS, 8'h00);
        send_item(scre_pkg::OP_DATA, 8'h00);
        send_item(scre_pkg::OP_DATA, 8'hFF);
        send_item(scre_pkg::OP_DATA, 8'h20);
        send_item(scre_pkg::OP_DATA, 8'h21);
        send_item(scre_pkg::OP_EOS, 8'h00);

        // run past the cap, then enough literals to reach the literal cap
        write_copy_count(16'd0);
        v = pick_byte();
        repeat (129) send_item(scre_pkg::OP_DATA, v);
        send_literals(128);
        send_item(scre_pkg::OP_EOS, 8'h00);

        stream_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 3) == 0);
            if (stream_no == 1)
                write_copy_count(16'hFFFF);
            else if (stream_no == 2)
                write_copy_count(16'd3);
            else if ($urandom_range(0, 2) == 0)
                write_copy_count(pick_copy_count());
            send_random_stream();
            stream_no++;
        end

        steady = 1'b0;
        wait_idle();
        @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/scre_pkg.sv
rtl/scre_lit_mem.sv
rtl/scre_ctrl.sv
rtl/signed_count_rle_encoder.sv
rtl/scre_checker.sv
tb/scre_stream_checker.sv
tb/signed_count_rle_encoder_tb.sv
